// ===== hw/rtl/wdr_pkg.sv =====
package wdr_pkg;

	// mantissa geometry
	localparam int LIMB_W    = 32;
	localparam int LIMBS     = 7;
	localparam int MANT_W    = LIMB_W * LIMBS;
	localparam int RES_W     = 96;
	localparam int SCALE_W   = 8;
	localparam int CNT_W     = $clog2(LIMBS);
	localparam logic [CNT_W-1:0] LAST_LIMB = CNT_W'(LIMBS - 1);

	// one limb step divides {rem, limb} by ten
	localparam int RADIX     = 10;
	localparam int REM_W     = 4;
	localparam int CUR_W     = LIMB_W + REM_W;
	localparam int PROD_W    = 2 * CUR_W;
	// ceil(2^39 / 10), exact for every dividend below 2^36
	localparam int RECIP_SHIFT = 39;
	localparam logic [CUR_W-1:0] RECIP = 36'd54975581389;
	localparam logic [REM_W-1:0] HALF_DIGIT = 4'd5;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_OVF_POS = 2'd1,
		STAT_OVF_NEG = 2'd2
	} status_t;

	typedef struct packed {
		logic [MANT_W-1:0]  mant;
		logic [SCALE_W-1:0] scale;
		logic               negative;
	} operand_t;

	typedef struct packed {
		logic load;
		logic pass_start;
		logic div_step;
		logic pass_end;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic wide;
		logic scale_zero;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== hw/rtl/wdr_in_if.sv =====
interface wdr_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] mant_word0;
	logic [63:0] mant_word1;
	logic [63:0] mant_word2;
	logic [31:0] mant_word3;
	logic [7:0]  in_scale;
	logic        in_negative;

	modport source (
		output valid, mant_word0, mant_word1, mant_word2, mant_word3, in_scale, in_negative,
		input  ready
	);
	modport sink (
		input  valid, mant_word0, mant_word1, mant_word2, mant_word3, in_scale, in_negative,
		output ready
	);
endinterface

// ===== hw/rtl/wdr_out_if.sv =====
interface wdr_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] res_low;
	logic [31:0] res_high;
	logic [7:0]  res_scale;
	logic        res_negative;
	logic [1:0]  status;

	modport source (
		output valid, res_low, res_high, res_scale, res_negative, status,
		input  ready
	);
	modport sink (
		input  valid, res_low, res_high, res_scale, res_negative, status,
		output ready
	);
endinterface

// ===== hw/rtl/wide_decimal_round_to_96_top.sv =====
// channel   dir  bus          payload
// operand   in   wdr_in_if    mant_word0..3 (224-bit mantissa), in_scale, in_negative
// result    out  wdr_out_if   res_low, res_high, res_scale, res_negative, status
//
// the number of divisions by ten is 0 when the mantissa already fits and at most 39;
// the next request is taken in the cycle after the result loads, so the block works
// on one item at a time
// each division walks the seven 32-bit limbs through one reciprocal multiplier,
// one limb per cycle, with a width test between passes
// a result waiting for ready holds the next item in rounding; arst_n clears only
// the controller and the result valid flag
module wide_decimal_round_to_96_top (
	input logic       clk,
	input logic       arst_n,
	wdr_in_if.sink    operand,
	wdr_out_if.source result
);
	import wdr_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	operand_t opnd;
	logic     in_ready;

	// gather the four input words into one mantissa, low word at the bottom
	assign opnd.mant     = {operand.mant_word3, operand.mant_word2,
		operand.mant_word1, operand.mant_word0};
	assign opnd.scale    = operand.in_scale;
	assign opnd.negative = operand.in_negative;

	// a request is taken only when the controller is idle
	assign operand.ready = in_ready;

	// sequencer: width test, limb stepping, rounding hand-off
	wdr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (operand.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// mantissa register, divide-by-ten limb unit, rounding and result register
	wdr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.opnd         (opnd),
		.out_valid    (result.valid),
		.out_ready    (result.ready),
		.res_low      (result.res_low),
		.res_high     (result.res_high),
		.res_scale    (result.res_scale),
		.res_negative (result.res_negative),
		.status       (result.status)
	);

endmodule

// ===== hw/rtl/wdr_ctrl.sv =====
module wdr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  wdr_pkg::dp_stat_t stat,
	output wdr_pkg::dp_cmd_t  cmd
);
	import wdr_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_TEST  = 4'b0010,
		S_DIV   = 4'b0100,
		S_ROUND = 4'b1000
	} state_t;

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_TEST;
				end
			end
			S_TEST: begin
				if (stat.wide && !stat.scale_zero) begin
					cmd.pass_start = 1'b1;
					state_d        = S_DIV;
				end else begin
					state_d = S_ROUND;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == LAST_LIMB) begin
					cmd.pass_end = 1'b1;
					state_d      = S_TEST;
				end
			end
			S_ROUND: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.pass_start) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// never overwrite a result that is still waiting
	a_finish_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> stat.out_free)
		else $error("result loaded while output slot busy");

	// a pass runs through all limbs without a break
	a_pass_continues: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step && !cmd.pass_end |=> cmd.div_step)
		else $error("division pass interrupted");

	a_pass_end_retest: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pass_end |=> state_q == S_TEST)
		else $error("no width test after division pass");

endmodule

// ===== hw/rtl/wdr_dp.sv =====
module wdr_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  wdr_pkg::dp_cmd_t  cmd,
	output wdr_pkg::dp_stat_t stat,
	input  wdr_pkg::operand_t opnd,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [63:0]       res_low,
	output logic [31:0]       res_high,
	output logic [7:0]        res_scale,
	output logic              res_negative,
	output wdr_pkg::status_t  status
);
	import wdr_pkg::*;

	logic [MANT_W-1:0]  mant_q;
	logic [SCALE_W-1:0] scale_q;
	logic               neg_q;
	logic [REM_W-1:0]   div_rem_q;
	logic [REM_W-1:0]   last_rem_q;
	logic               sticky_q;

	logic [RES_W-1:0]   res_mant_q;
	logic [SCALE_W-1:0] res_scale_q;
	logic               res_neg_q;
	status_t            status_q;
	logic               out_valid_q;

	logic [CUR_W-1:0]   cur;
	logic [PROD_W-1:0]  prod;
	logic [LIMB_W-1:0]  quo;
	logic [REM_W-1:0]   rem_new;
	logic               wide;
	logic               round_up;
	logic [RES_W:0]     rounded;
	logic               ovf;

	// one limb of the long division by ten, top limb first
	assign cur     = {div_rem_q, mant_q[MANT_W-1 -: LIMB_W]};
	assign prod    = PROD_W'(cur) * PROD_W'(RECIP);
	assign quo     = prod[RECIP_SHIFT +: LIMB_W];
	assign rem_new = REM_W'(cur - CUR_W'(quo) * CUR_W'(RADIX));

	assign wide = |mant_q[MANT_W-1:RES_W];

	// half to even, with the sticky bit breaking ties upward
	assign round_up = (last_rem_q > HALF_DIGIT)
		|| ((last_rem_q == HALF_DIGIT) && (sticky_q || mant_q[0]));
	assign rounded  = {1'b0, mant_q[RES_W-1:0]} + (RES_W + 1)'(round_up);
	assign ovf      = wide || rounded[RES_W];

	assign stat.wide       = wide;
	assign stat.scale_zero = (scale_q == '0);
	assign stat.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mant_q     <= opnd.mant;
			scale_q    <= opnd.scale;
			neg_q      <= opnd.negative;
			last_rem_q <= '0;
			sticky_q   <= 1'b0;
		end
		if (cmd.pass_start) begin
			sticky_q  <= sticky_q || (last_rem_q != '0);
			div_rem_q <= '0;
		end
		if (cmd.div_step) begin
			// rotate: quotient limbs enter at the bottom, in order after a full pass
			mant_q    <= {mant_q[MANT_W-LIMB_W-1:0], quo};
			div_rem_q <= rem_new;
		end
		if (cmd.pass_end) begin
			last_rem_q <= rem_new;
			scale_q    <= scale_q - 1'b1;
		end
		if (cmd.finish) begin
			if (ovf) begin
				res_mant_q  <= '0;
				res_scale_q <= '0;
				res_neg_q   <= 1'b0;
				status_q    <= neg_q ? STAT_OVF_NEG : STAT_OVF_POS;
			end else begin
				res_mant_q  <= rounded[RES_W-1:0];
				res_scale_q <= scale_q;
				res_neg_q   <= neg_q;
				status_q    <= STAT_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign res_low      = res_mant_q[63:0];
	assign res_high     = res_mant_q[RES_W-1:64];
	assign res_scale    = res_scale_q;
	assign res_negative = res_neg_q;
	assign status       = status_q;

	// a bad reciprocal would let the running remainder escape 0..9
	a_rem_digit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> div_rem_q < REM_W'(RADIX))
		else $error("division remainder out of range");

	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != STAT_OK |-> res_mant_q == '0 && res_scale_q == '0
			&& !res_neg_q)
		else $error("overflow result not zero");

	a_sticky_holds: assert property (@(posedge clk) disable iff (!arst_n)
		sticky_q && !cmd.load |=> sticky_q)
		else $error("sticky flag dropped within an item");

endmodule
